// File: hw/rtl/itbl_pkg.sv
// Shared constants and types for the indexed table engine.
// No dependencies; used by indexed_table_engine.
package itbl_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned LEN_W     = IDX_W + 1;
  localparam int unsigned ACT_W     = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_FIND   = 3'd4
  } action_e;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SHIFT   = 5'b00010,
    S_COMPACT = 5'b00100,
    S_READ    = 5'b01000,
    S_FIND    = 5'b10000
  } state_e;

endpackage

// File: hw/rtl/itbl_ram.sv
// Generic single-write, single-read RAM with registered, enabled read port.
// No dependencies; used by indexed_table_engine for the entry store.
module itbl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/indexed_table_engine.sv
// Indexed table engine: ordered word table with append, insert, remove, read, find.
// Depends on itbl_pkg and itbl_ram.
//
// One transaction is taken at a time; in_ready_o is high only while the engine
// is idle and its output register is free. Append, insert at or past the end,
// refused adds, reads past the length and unused actions finish in the accept
// cycle. Read registers the word in the entry RAM, then emits it. Insert moves
// the entries from its position to the end up one place, then writes the word;
// remove and find walk all entries. Every result also waits for the output register.
// Each walk reads one word per cycle (a find can be held while a result is untaken)
// through the entry RAM's registered read port; shift and compact write back
// through its separate write port; compact and find share a single comparator.
// Entries are not cleared at reset, so the block is ready right after reset.
module indexed_table_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [itbl_pkg::ACT_W-1:0]       action_i,
  input  logic [itbl_pkg::LEN_W-1:0]       position_i,
  input  logic [itbl_pkg::WORD_BITS-1:0]   word_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [itbl_pkg::WORD_BITS-1:0]   word_out_o,
  output logic [itbl_pkg::IDX_W-1:0]       match_index_o,
  output logic                             found_o,
  output logic [itbl_pkg::LEN_W-1:0]       table_length_o,
  output logic                             failed_o,
  output logic                             last_o
);

  itbl_pkg::state_e state_q, state_d;
  logic [itbl_pkg::LEN_W-1:0]     used_q, used_d;
  logic [itbl_pkg::LEN_W-1:0]     idx_q, idx_d;
  logic [itbl_pkg::LEN_W-1:0]     wr_q, wr_d;
  logic [itbl_pkg::LEN_W-1:0]     pos_q, pos_d;
  logic [itbl_pkg::WORD_BITS-1:0] word_q, word_d;
  logic                           dv_q, dv_d;
  logic                           pend_q, pend_d;
  logic [itbl_pkg::IDX_W-1:0]     pend_idx_q, pend_idx_d;

  logic                           out_valid_q, out_valid_d;
  logic [itbl_pkg::WORD_BITS-1:0] out_word_q;
  logic [itbl_pkg::IDX_W-1:0]     out_idx_q;
  logic                           out_found_q, out_fail_q, out_last_q;
  logic [itbl_pkg::LEN_W-1:0]     out_len_q;

  logic                           emit;
  logic [itbl_pkg::WORD_BITS-1:0] e_word;
  logic [itbl_pkg::IDX_W-1:0]     e_idx;
  logic                           e_found, e_fail, e_last;
  logic [itbl_pkg::LEN_W-1:0]     e_len;

  logic                           ram_we, ram_re;
  logic [itbl_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [itbl_pkg::WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                           out_free, accept, hit;
  logic [itbl_pkg::LEN_W-1:0]     idx_p1, idx_m1, used_p1;

  itbl_ram #(
    .WIDTH (itbl_pkg::WORD_BITS),
    .DEPTH (itbl_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == itbl_pkg::S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign idx_p1     = idx_q + itbl_pkg::LEN_W'(1);
  assign idx_m1     = idx_q - itbl_pkg::LEN_W'(1);
  assign used_p1    = used_q + itbl_pkg::LEN_W'(1);
  assign hit        = dv_q && (ram_rdata == word_q);

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    idx_d      = idx_q;
    wr_d       = wr_q;
    pos_d      = pos_q;
    word_d     = word_q;
    dv_d       = dv_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    emit       = 1'b0;
    e_word     = '0;
    e_idx      = '0;
    e_found    = 1'b0;
    e_fail     = 1'b0;
    e_last     = 1'b1;
    e_len      = used_q;

    unique case (state_q)
      itbl_pkg::S_IDLE: begin
        if (accept) begin
          pos_d  = position_i;
          word_d = word_in_i;
          idx_d  = '0;
          wr_d   = '0;
          dv_d   = 1'b0;
          pend_d = 1'b0;
          case (action_i) inside
            itbl_pkg::ACT_APPEND, itbl_pkg::ACT_INSERT: begin
              if (used_q == itbl_pkg::LEN_W'(itbl_pkg::DEPTH)) begin
                emit   = 1'b1;
                e_fail = 1'b1;
              end else if (action_i == itbl_pkg::ACT_INSERT && position_i < used_q) begin
                idx_d   = used_q;
                state_d = itbl_pkg::S_SHIFT;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = used_q[itbl_pkg::IDX_W-1:0];
                ram_wdata = word_in_i;
                used_d    = used_p1;
                emit      = 1'b1;
                e_len     = used_p1;
              end
            end
            itbl_pkg::ACT_REMOVE: state_d = itbl_pkg::S_COMPACT;
            itbl_pkg::ACT_READ: begin
              if (position_i < used_q) begin
                ram_re    = 1'b1;
                ram_raddr = position_i[itbl_pkg::IDX_W-1:0];
                state_d   = itbl_pkg::S_READ;
              end else begin
                emit   = 1'b1;
                e_fail = 1'b1;
              end
            end
            itbl_pkg::ACT_FIND: state_d = itbl_pkg::S_FIND;
            default: emit = 1'b1;
          endcase
        end
      end

      itbl_pkg::S_SHIFT: begin
        if (dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_p1[itbl_pkg::IDX_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_q > pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_m1[itbl_pkg::IDX_W-1:0];
          idx_d     = idx_m1;
          dv_d      = 1'b1;
        end else begin
          dv_d = 1'b0;
          if (!dv_q && out_free) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q[itbl_pkg::IDX_W-1:0];
            ram_wdata = word_q;
            used_d    = used_p1;
            emit      = 1'b1;
            e_len     = used_p1;
            state_d   = itbl_pkg::S_IDLE;
          end
        end
      end

      itbl_pkg::S_COMPACT: begin
        if (dv_q && !hit) begin
          ram_we    = 1'b1;
          ram_waddr = wr_q[itbl_pkg::IDX_W-1:0];
          ram_wdata = ram_rdata;
          wr_d      = wr_q + itbl_pkg::LEN_W'(1);
        end
        if (idx_q < used_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[itbl_pkg::IDX_W-1:0];
          idx_d     = idx_p1;
          dv_d      = 1'b1;
        end else begin
          dv_d = 1'b0;
          if (!dv_q && out_free) begin
            used_d  = wr_q;
            emit    = 1'b1;
            e_len   = wr_q;
            state_d = itbl_pkg::S_IDLE;
          end
        end
      end

      itbl_pkg::S_READ: begin
        if (out_free) begin
          emit    = 1'b1;
          e_word  = ram_rdata;
          state_d = itbl_pkg::S_IDLE;
        end
      end

      itbl_pkg::S_FIND: begin
        // a held match goes out only once the next match or the end is seen
        if (!(hit && pend_q && !out_free)) begin
          if (hit) begin
            if (pend_q) begin
              emit    = 1'b1;
              e_idx   = pend_idx_q;
              e_found = 1'b1;
              e_last  = 1'b0;
            end
            pend_d     = 1'b1;
            pend_idx_d = idx_m1[itbl_pkg::IDX_W-1:0];
          end
          if (idx_q < used_q) begin
            ram_re    = 1'b1;
            ram_raddr = idx_q[itbl_pkg::IDX_W-1:0];
            idx_d     = idx_p1;
            dv_d      = 1'b1;
          end else begin
            dv_d = 1'b0;
            if (!dv_q && out_free) begin
              emit    = 1'b1;
              e_found = pend_q;
              e_idx   = pend_q ? pend_idx_q : '0;
              state_d = itbl_pkg::S_IDLE;
            end
          end
        end
      end

      default: state_d = itbl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itbl_pkg::S_IDLE;
      used_q      <= '0;
      dv_q        <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      dv_q        <= dv_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    wr_q       <= wr_d;
    pos_q      <= pos_d;
    word_q     <= word_d;
    pend_idx_q <= pend_idx_d;
    if (emit) begin
      out_word_q  <= e_word;
      out_idx_q   <= e_idx;
      out_found_q <= e_found;
      out_fail_q  <= e_fail;
      out_last_q  <= e_last;
      out_len_q   <= e_len;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_out_o     = out_word_q;
  assign match_index_o  = out_idx_q;
  assign found_o        = out_found_q;
  assign table_length_o = out_len_q;
  assign failed_o       = out_fail_q;
  assign last_o         = out_last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= itbl_pkg::LEN_W'(itbl_pkg::DEPTH))
    else $error("fill count past capacity");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itbl_pkg::S_SHIFT |-> (idx_q >= pos_q) && (pos_q < used_q))
    else $error("insert shift out of range");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itbl_pkg::S_COMPACT |-> wr_q <= idx_q)
    else $error("compaction write pointer ahead of read pointer");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result loaded over an untaken result");

endmodule
